@@ src/rgb_linear_fade_dimmer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the RGB linear fade dimmer
// Clocked property wrappers used by the top module of this block.
// ----------------------------------------------------------------------------
`ifndef RGB_LINEAR_FADE_DIMMER_TOP_MACROS_SVH
`define RGB_LINEAR_FADE_DIMMER_TOP_MACROS_SVH

// Check a property on every rising edge outside reset
`define RLFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define RLFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/rlfd_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB linear fade dimmer package
// Command codes, channel count and scaling constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlfd_pkg;

    // Command codes
    typedef logic [1:0] t_func;
    localparam t_func FUNC_TICK = 2'd0;
    localparam t_func FUNC_SET  = 2'd1;
    localparam t_func FUNC_FADE = 2'd2;

    typedef logic [7:0]  t_color;
    typedef logic [15:0] t_count;
    typedef logic [31:0] t_level;
    typedef logic [6:0]  t_bright;
    typedef logic [1:0]  t_ch;
    typedef logic [4:0]  t_divcnt;

    localparam int   NUM_CH  = 3;
    localparam t_ch  CH_LAST = 2'(NUM_CH - 1);
    localparam int   DIV_BITS = 32;

    localparam t_bright BRIGHT_MAX   = 7'd100;
    localparam t_bright BRIGHT_RESET = 7'd100;

    // Exact reciprocals for 32-bit unsigned division by 100 and by 10
    localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
    localparam int          SHIFT_100 = 37;
    localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;
    localparam int          SHIFT_10  = 35;

endpackage

@@ src/rlfd_ifs.sv @@
// ----------------------------------------------------------------------------
// RGB linear fade dimmer channels
// Command and result valid/ready channels with their payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rlfd_cmd_if;
    import rlfd_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_color red;
    t_color green;
    t_color blue;
    t_count fade_steps;
    t_count step_delay;
    logic   dim_request;
    logic   skip_wait;

    modport source (
        output valid, func, red, green, blue, fade_steps, step_delay,
               dim_request, skip_wait,
        input  ready
    );
    modport sink (
        input  valid, func, red, green, blue, fade_steps, step_delay,
               dim_request, skip_wait,
        output ready
    );
endinterface

interface rlfd_res_if;
    import rlfd_pkg::*;

    logic   valid;
    logic   ready;
    t_color shown_red;
    t_color shown_green;
    t_color shown_blue;
    logic   level_changed;
    logic   fading;

    modport source (
        output valid, shown_red, shown_green, shown_blue, level_changed, fading,
        input  ready
    );
    modport sink (
        input  valid, shown_red, shown_green, shown_blue, level_changed, fading,
        output ready
    );
endinterface

@@ src/rgb_linear_fade_dimmer_top.sv @@
// ----------------------------------------------------------------------------
// RGB linear fade dimmer
// Three-channel LED fader with a shared bit-serial divider for fade
// increments and a shared multiplier for brightness and dim scaling.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per transaction: a one-millisecond tick, a set
//   colour, or a fade start (targets, step count, step delay). o_res returns
//   exactly one result per command: the shown colour after brightness and dim
//   scaling, a level-changed flag and the fading flag.
//   The user must write the brightness percent through i_brightness_we /
//   i_brightness only while idle; the block itself does not enforce it. A
//   tick, set or ignored command runs from acceptance to the result register
//   through decode, a step state per channel when a fade step is due, the
//   scaling states A to D (D only when dimmed) per channel, and push. A fade
//   start first runs a divider setup and, if it moves, a divide per channel.
//   One command is worked on at a time; i_cmd.ready is high only when the
//   sequencer is idle, so a new command is taken only after the last is
//   pushed. The result register lets the next command enter while the
//   previous result still waits on o_res. Reset (synchronous, active low)
//   clears all levels, targets, increments, counters, the dim, fade, last,
//   changed and result-valid flags, and sets brightness to 100. While o_res
//   stalls, the finished result holds; a later result waits in the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_linear_fade_dimmer_top #(
    parameter int FRACTION_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_brightness_we,
    input  rlfd_pkg::t_bright  i_brightness,
    rlfd_cmd_if.sink           i_cmd,
    rlfd_res_if.source         o_res
);
    import rlfd_pkg::*;

    `include "rgb_linear_fade_dimmer_top_macros.svh"

    // Sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_STEP     = 4'd2;
    localparam logic [3:0] ST_DV_SETUP = 4'd3;
    localparam logic [3:0] ST_DV_RUN   = 4'd4;
    localparam logic [3:0] ST_DV_DONE  = 4'd5;
    localparam logic [3:0] ST_SH_A     = 4'd6;
    localparam logic [3:0] ST_SH_B     = 4'd7;
    localparam logic [3:0] ST_SH_C     = 4'd8;
    localparam logic [3:0] ST_SH_D     = 4'd9;
    localparam logic [3:0] ST_PUSH     = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Latched command
    t_func  r_func;
    t_color r_col [NUM_CH];
    t_count r_steps;
    t_count r_delay;
    logic   r_dimreq;
    logic   r_skip;

    // Fader state
    t_level r_level [NUM_CH];
    t_level r_target [NUM_CH];
    t_level r_inc [NUM_CH];
    t_count r_steps_left;
    t_count r_wait;
    t_count r_delay_set;
    logic   r_dim;
    logic   r_fade;
    t_bright r_bright;

    // Work registers
    t_ch     r_ch;
    logic    r_last;
    logic    r_changed;
    t_level  r_quo;
    t_count  r_rem;
    logic    r_up;
    t_divcnt r_cnt;
    logic [63:0] r_prod;
    t_color  r_shown [NUM_CH];

    // Result register
    logic   r_out_valid;
    t_color r_out_col [NUM_CH];
    logic   r_out_changed;
    logic   r_out_fading;

    logic   w_accept;
    logic   w_push;
    logic   w_stalled;
    logic   w_div_last;
    t_count w_wait_next;
    t_level w_tgt;
    t_level w_lvl;
    t_level w_step_lvl;
    logic   w_step_chg;
    logic [16:0] w_rem_sh;
    logic [16:0] w_rem_sub;
    logic   w_ge;
    t_bright w_bright;
    t_level w_mul_a;
    t_level w_mul_b;
    logic [63:0] w_prod;
    t_level w_scaled;
    t_color w_disp;
    logic   w_nz;
    t_color w_shown;

    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign w_push      = (r_state == ST_PUSH) && (!r_out_valid || o_res.ready);
    assign w_stalled   = (r_state == ST_PUSH) && r_out_valid && !o_res.ready;

    // Channel operands
    assign w_lvl = r_level[r_ch];
    assign w_tgt = 32'(r_col[r_ch]) << FRACTION_BITS;

    // Tick delay countdown
    assign w_wait_next = r_skip ? '0 : ((r_wait != '0) ? r_wait - 16'd1 : '0);

    // Shared adder for one fade step
    assign w_step_lvl = r_last ? r_target[r_ch] : w_lvl + r_inc[r_ch];
    assign w_step_chg = (w_step_lvl >> FRACTION_BITS) != (w_lvl >> FRACTION_BITS);

    // Restoring divider iteration
    assign w_rem_sh   = {r_rem, r_quo[DIV_BITS-1]};
    assign w_rem_sub  = w_rem_sh - {1'b0, r_steps};
    assign w_ge       = (w_rem_sh >= {1'b0, r_steps});
    assign w_div_last = (r_state == ST_DV_RUN) && (r_cnt == 5'(DIV_BITS - 1));

    // Shared multiplier operands
    assign w_bright = (r_bright > BRIGHT_MAX) ? BRIGHT_MAX : r_bright;

    always_comb begin
        unique case (r_state)
            ST_SH_A: begin
                w_mul_a = w_lvl;
                w_mul_b = RECIP_100;
            end
            ST_SH_B: begin
                w_mul_a = 32'(r_prod[63:SHIFT_100]);
                w_mul_b = 32'(w_bright);
            end
            ST_SH_C: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = RECIP_10;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // Final display value for the current channel
    assign w_scaled = (r_state == ST_SH_D) ? {1'b0, r_prod[63:SHIFT_10], 2'b00}
                                           : r_prod[31:0];
    assign w_disp   = w_scaled[FRACTION_BITS +: 8];
    assign w_nz     = (w_lvl >> FRACTION_BITS) != '0;
    assign w_shown  = (w_disp == '0 && w_nz) ? 8'd1 : w_disp;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (r_func)
                    FUNC_TICK: begin
                        if (r_steps_left != '0 && w_wait_next == '0) begin
                            n_state = ST_STEP;
                        end else begin
                            n_state = ST_SH_A;
                        end
                    end
                    FUNC_FADE: n_state = ST_DV_SETUP;
                    default:   n_state = ST_SH_A;
                endcase
            end
            ST_STEP: begin
                if (r_ch == CH_LAST) begin
                    n_state = ST_SH_A;
                end
            end
            ST_DV_SETUP: begin
                if (r_steps != '0 && w_lvl != w_tgt) begin
                    n_state = ST_DV_RUN;
                end else if (r_ch == CH_LAST) begin
                    n_state = ST_SH_A;
                end
            end
            ST_DV_RUN: begin
                if (w_div_last) begin
                    n_state = ST_DV_DONE;
                end
            end
            ST_DV_DONE: begin
                n_state = (r_ch == CH_LAST) ? ST_SH_A : ST_DV_SETUP;
            end
            ST_SH_A: n_state = ST_SH_B;
            ST_SH_B: n_state = ST_SH_C;
            ST_SH_C: begin
                if (r_dim) begin
                    n_state = ST_SH_D;
                end else if (r_ch == CH_LAST) begin
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_SH_A;
                end
            end
            ST_SH_D: n_state = (r_ch == CH_LAST) ? ST_PUSH : ST_SH_A;
            ST_PUSH: begin
                if (w_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer and fader state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_steps_left <= '0;
            r_wait       <= '0;
            r_delay_set  <= '0;
            r_dim        <= 1'b0;
            r_fade       <= 1'b0;
            r_bright     <= BRIGHT_RESET;
            r_ch         <= '0;
            r_last       <= 1'b0;
            r_changed    <= 1'b0;
            r_cnt        <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_level[i]  <= '0;
                r_target[i] <= '0;
                r_inc[i]    <= '0;
            end
        end else begin
            r_state <= n_state;

            // Take configuration writes at any time
            if (i_brightness_we) begin
                r_bright <= i_brightness;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_ch <= '0;
                end
                ST_DECODE: begin
                    r_changed <= 1'b0;
                    unique case (r_func)
                        FUNC_TICK: begin
                            if (r_steps_left != '0) begin
                                if (w_wait_next == '0) begin
                                    r_last       <= (r_steps_left == 16'd1);
                                    r_steps_left <= r_steps_left - 16'd1;
                                    r_wait       <= r_delay_set;
                                end else begin
                                    r_wait <= w_wait_next;
                                end
                            end
                        end
                        FUNC_SET: begin
                            for (int i = 0; i < NUM_CH; i++) begin
                                r_level[i]  <= 32'(r_col[i]) << FRACTION_BITS;
                                r_target[i] <= 32'(r_col[i]) << FRACTION_BITS;
                                r_inc[i]    <= '0;
                            end
                            r_dim        <= r_dimreq;
                            r_fade       <= 1'b0;
                            r_steps_left <= '0;
                        end
                        FUNC_FADE: begin
                            r_steps_left <= r_steps;
                            r_delay_set  <= r_delay;
                            r_fade       <= 1'b1;
                            r_dim        <= 1'b0;
                            r_wait       <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_STEP: begin
                    r_level[r_ch] <= w_step_lvl;
                    if (w_step_chg) begin
                        r_changed <= 1'b1;
                    end
                    r_ch <= (r_ch == CH_LAST) ? '0 : r_ch + 2'd1;
                end
                ST_DV_SETUP: begin
                    r_target[r_ch] <= w_tgt;
                    r_cnt          <= '0;
                    if (r_steps != '0 && w_lvl != w_tgt) begin
                        r_up <= (w_tgt > w_lvl);
                        r_quo <= (w_tgt > w_lvl) ? w_tgt - w_lvl : w_lvl - w_tgt;
                        r_rem <= '0;
                    end else begin
                        r_inc[r_ch] <= '0;
                        r_ch <= (r_ch == CH_LAST) ? '0 : r_ch + 2'd1;
                    end
                end
                ST_DV_RUN: begin
                    r_rem <= w_ge ? w_rem_sub[15:0] : w_rem_sh[15:0];
                    r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
                    r_cnt <= r_cnt + 5'd1;
                end
                ST_DV_DONE: begin
                    r_inc[r_ch] <= r_up ? r_quo : ~r_quo;
                    r_ch <= (r_ch == CH_LAST) ? '0 : r_ch + 2'd1;
                end
                ST_SH_A, ST_SH_B: begin
                    r_prod <= w_prod;
                end
                ST_SH_C: begin
                    if (r_dim) begin
                        r_prod <= w_prod;
                    end else begin
                        r_shown[r_ch] <= w_shown;
                        r_ch <= (r_ch == CH_LAST) ? '0 : r_ch + 2'd1;
                    end
                end
                ST_SH_D: begin
                    r_shown[r_ch] <= w_shown;
                    r_ch <= (r_ch == CH_LAST) ? '0 : r_ch + 2'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // Capture the command payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func    <= i_cmd.func;
            r_col[0]  <= i_cmd.red;
            r_col[1]  <= i_cmd.green;
            r_col[2]  <= i_cmd.blue;
            r_steps   <= i_cmd.fade_steps;
            r_delay   <= i_cmd.step_delay;
            r_dimreq  <= i_cmd.dim_request;
            r_skip    <= i_cmd.skip_wait;
        end
    end

    // Result register: hold until taken, load when free or drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_out_col[i] <= r_shown[i];
            end
            r_out_changed <= r_changed;
            r_out_fading  <= r_fade && (r_steps_left != '0);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.shown_red     = r_out_col[0];
    assign o_res.shown_green   = r_out_col[1];
    assign o_res.shown_blue    = r_out_col[2];
    assign o_res.level_changed = r_out_changed;
    assign o_res.fading        = r_out_fading;

    // Assertions
    `RLFD_ASSERT(a_busy_after_accept, w_accept |=> !i_cmd.ready, "ready after accept")
    `RLFD_ASSERT(a_div_ends, w_div_last |=> (r_state == ST_DV_DONE), "divider overrun")
    `RLFD_ASSERT(a_push_waits, w_stalled |=> (r_state == ST_PUSH && r_out_valid), "lost result")
    `RLFD_ASSERT(a_changed_tick, (w_push && r_changed) |-> (r_func == FUNC_TICK), "bad change")

endmodule
